@@ rtl/corner_deviation_match_scorer_assert.svh @@
// ============================================================================
// Corner deviation match scorer assertion macros
// Shared property forms for the block's concurrent checks.
// ============================================================================
`ifndef CORNER_DEVIATION_MATCH_SCORER_ASSERT_SVH
`define CORNER_DEVIATION_MATCH_SCORER_ASSERT_SVH

// same-cycle implication
`define CDMS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cdms check failed");

// next-cycle implication
`define CDMS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cdms check failed");

`endif

@@ rtl/cdms_pkg.sv @@
// ============================================================================
// Corner deviation match scorer package
// Widths, reset values, codes and sequencer states shared by the block.
// ============================================================================
package cdms_pkg;

   localparam int COORD_W         = 16;
   localparam int D_W             = 17;
   localparam int IMG_W           = 16;
   localparam int THR_W           = 17;
   localparam int SCORE_W         = 17;
   localparam int SCORE_FRAC_W    = 16;
   localparam int CSR_IDX_W       = 1;
   localparam int MAX_CORNERS_DEF = 64;

   localparam logic [IMG_W-1:0]   IMAGE_TOTAL_RST = 16'd100;
   localparam logic [THR_W-1:0]   THRESHOLD_RST   = 17'd64;
   localparam logic [IMG_W-1:0]   COUNT_MAX       = 16'hFFFF;
   localparam logic [SCORE_W-1:0] SCORE_ONE       = 17'h10000;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_TOTAL     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_THRESHOLD = 1'd1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_RAD,
      ST_ROOT_D,
      ST_STORE,
      ST_DECIDE,
      ST_CP_RD,
      ST_CP_MUL,
      ST_CP_ACC,
      ST_M_NSQ,
      ST_M_SUM,
      ST_M_NN,
      ST_M_TN,
      ST_M_TT,
      ST_CMP,
      ST_DIV_V,
      ST_ROOT_V,
      ST_SCORE,
      ST_DIV_S,
      ST_OUT
   } state_type;

endpackage

@@ rtl/cdms_mul.sv @@
// ============================================================================
// Shared multiplier
// Unsigned product with a register on the output.
// ============================================================================
module cdms_mul
   import cdms_pkg::*;
#(
   parameter int A_W = 2 * D_W,
   parameter int B_W = D_W
) (
   input  logic               clock,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic [A_W+B_W-1:0] p
);

   logic [A_W+B_W-1:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
   end

   assign p = p_ff;

endmodule

@@ rtl/cdms_sqrt.sv @@
// ============================================================================
// Iterative square root
// Restoring floor square root, one result bit per cycle.
// ============================================================================
module cdms_sqrt
   import cdms_pkg::*;
#(
   parameter int RAD_W = 2 * D_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [RAD_W-1:0]     radicand,
   output logic [RAD_W/2-1:0]   root,
   output logic                 done
);

   localparam int ROOT_W = RAD_W / 2;
   localparam int CNT_W  = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W:0]   rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [ROOT_W+2:0] rem_t;
   logic [ROOT_W+2:0] trial;
   logic [ROOT_W+2:0] diff;
   logic              ge;

   assign rem_t = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign diff  = rem_t - trial;
   assign ge    = rem_t >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ROOT_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= ge ? diff[ROOT_W:0] : rem_t[ROOT_W:0];
         root_ff <= {root_ff[ROOT_W-2:0], ge};
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

@@ rtl/cdms_div.sv @@
// ============================================================================
// Iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// ============================================================================
module cdms_div
   import cdms_pkg::*;
#(
   parameter int NUM_W = 48,
   parameter int DIV_W = IMG_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic [NUM_W-1:0] quotient,
   output logic             done
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DIV_W:0]   rem_t;
   logic [DIV_W:0]   diff;
   logic             ge;

   assign rem_t = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = rem_t - {1'b0, dvs_ff};
   assign ge    = rem_t >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DIV_W-1:0] : rem_t[DIV_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

@@ rtl/corner_deviation_match_scorer.sv @@
// ============================================================================
// Corner deviation match scorer
// Scores corner agreement between a reference and a test image.
// ============================================================================
// Usage: send corner pair items on the req_ channel, one image at a time,
// with req_last on the final pair. A req_cmd clear item zeroes the good and
// skipped counters and returns nothing. Each sample item with req_last gives
// one item on the rsp_ channel: deviation, match flag, counters and score.
// Write image_total and match_threshold through the csr_ port while idle.
// A stored pair holds req_stall while the multiplier squares dx and dy,
// the one-bit-per-cycle square root of 17 steps runs to its done, and the
// distance is stored. If the last pair has both corners found and distances
// are stored, the closing pass reads, squares and sums each stored distance
// in turn, then runs its multiplies, a divide and a square root; the score
// takes another divide if image_total exceeds the skipped count. req_stall
// stays high while an item is in work; one item at a time.
// Stalling rsp_ holds the result register; the next item is taken meanwhile,
// and a further result waits until the register frees.
// Reset: counters and accumulation clear, registers return to 100 and 64;
// the distance memory is not cleared (only written entries are read).
// ============================================================================
module corner_deviation_match_scorer
   import cdms_pkg::*;
#(
   parameter int MAX_CORNERS = MAX_CORNERS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [THR_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  logic                 req_reference_found,
   input  logic                 req_test_found,
   input  logic [COORD_W-1:0]   req_ref_x,
   input  logic [COORD_W-1:0]   req_ref_y,
   input  logic [COORD_W-1:0]   req_test_x,
   input  logic [COORD_W-1:0]   req_test_y,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [D_W-1:0]       rsp_deviation,
   output logic                 rsp_deviation_valid,
   output logic                 rsp_good_match,
   output logic [IMG_W-1:0]     rsp_good_count,
   output logic [IMG_W-1:0]     rsp_skipped_count,
   output logic [SCORE_W-1:0]   rsp_score,
   output logic                 rsp_score_valid
);

   localparam int CNT_W = $clog2(MAX_CORNERS + 1);
   localparam int AW    = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;
   localparam int SUM_W = D_W + CNT_W;
   localparam int SQ_W  = 2 * D_W + CNT_W;
   localparam int NUM_W = 2 * D_W + 2 * CNT_W;
   localparam int MA_W  = SQ_W;
   localparam int MB_W  = SUM_W;
   localparam int P_W   = MA_W + MB_W;
   localparam int RAD_W = 2 * D_W;
   localparam int DV_W  = (2 * CNT_W > IMG_W) ? 2 * CNT_W : IMG_W;

   state_type state_ff, state_in;

   logic [IMG_W-1:0]   image_total_ff;
   logic [THR_W-1:0]   thr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [IMG_W-1:0]   good_ff;
   logic [IMG_W-1:0]   skip_ff;
   logic               rsp_valid_ff;

   logic               rf_ff, tf_ff, last_ff;
   logic [COORD_W-1:0] dx_ff, dy_ff;
   logic [NUM_W-1:0]   acc_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [DV_W-1:0]    den_ff;
   logic [SQ_W-1:0]    sq_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic [D_W-1:0]     rd_ff;
   logic [D_W-1:0]     dev_ff;
   logic               devv_ff;
   logic               hit_ff;
   logic [SCORE_W-1:0] score_ff;
   logic               sv_ff;

   logic [D_W-1:0]     rsp_deviation_ff;
   logic               rsp_deviation_valid_ff;
   logic               rsp_good_match_ff;
   logic [IMG_W-1:0]   rsp_good_count_ff;
   logic [IMG_W-1:0]   rsp_skipped_count_ff;
   logic [SCORE_W-1:0] rsp_score_ff;
   logic               rsp_score_valid_ff;

   logic [D_W-1:0]     mem [MAX_CORNERS];

   logic               req_fire;
   logic               store_ok;
   logic               out_load;
   logic               score_pos;
   logic [RAD_W-1:0]   rad_dist;
   logic [SCORE_W-1:0] score_sat;

   logic [MA_W-1:0]    mul_a;
   logic [MB_W-1:0]    mul_b;
   logic [P_W-1:0]     mul_p;
   logic               sqrt_start;
   logic [RAD_W-1:0]   sqrt_rad;
   logic [D_W-1:0]     sqrt_root;
   logic               sqrt_done;
   logic               div_start;
   logic [NUM_W-1:0]   div_num;
   logic [DV_W-1:0]    div_dvs;
   logic [NUM_W-1:0]   div_quo;
   logic               div_done;

   cdms_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   cdms_sqrt #(.RAD_W(RAD_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_rad),
      .root     (sqrt_root),
      .done     (sqrt_done)
   );

   cdms_div #(.NUM_W(NUM_W), .DIV_W(DV_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_dvs),
      .quotient (div_quo),
      .done     (div_done)
   );

   assign req_fire  = req_valid && !req_stall;
   assign store_ok  = req_reference_found && req_test_found &&
                      (count_ff < CNT_W'(MAX_CORNERS));
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign score_pos = image_total_ff > skip_ff;
   assign rad_dist  = acc_ff[RAD_W-1:0] + mul_p[RAD_W-1:0];
   assign score_sat = (div_quo > NUM_W'(SCORE_ONE)) ? SCORE_ONE : div_quo[SCORE_W-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_cmd == CMD_SAMPLE) begin
               if (store_ok) state_in = ST_SQ_X;
               else if (req_last) state_in = ST_DECIDE;
            end
         end
         ST_SQ_X:   state_in = ST_SQ_Y;
         ST_SQ_Y:   state_in = ST_RAD;
         ST_RAD:    state_in = ST_ROOT_D;
         ST_ROOT_D: if (sqrt_done) state_in = ST_STORE;
         ST_STORE:  state_in = last_ff ? ST_DECIDE : ST_IDLE;
         ST_DECIDE: begin
            if (rf_ff && tf_ff && count_ff != '0) state_in = ST_CP_RD;
            else state_in = ST_SCORE;
         end
         ST_CP_RD:  state_in = ST_CP_MUL;
         ST_CP_MUL: state_in = ST_CP_ACC;
         ST_CP_ACC: begin
            if (idx_ff + 1'b1 == count_ff) state_in = ST_M_NSQ;
            else state_in = ST_CP_RD;
         end
         ST_M_NSQ:  state_in = ST_M_SUM;
         ST_M_SUM:  state_in = ST_M_NN;
         ST_M_NN:   state_in = ST_M_TN;
         ST_M_TN:   state_in = ST_M_TT;
         ST_M_TT:   state_in = ST_CMP;
         ST_CMP:    state_in = ST_DIV_V;
         ST_DIV_V:  if (div_done) state_in = ST_ROOT_V;
         ST_ROOT_V: if (sqrt_done) state_in = ST_SCORE;
         ST_SCORE:  state_in = score_pos ? ST_DIV_S : ST_OUT;
         ST_DIV_S:  if (div_done) state_in = ST_OUT;
         ST_OUT:    if (out_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      mul_a      = '0;
      mul_b      = '0;
      sqrt_start = 1'b0;
      sqrt_rad   = rad_dist;
      div_start  = 1'b0;
      div_num    = num_ff;
      div_dvs    = den_ff;
      case (state_ff)
         ST_SQ_X: begin
            mul_a = MA_W'(dx_ff);
            mul_b = MB_W'(dx_ff);
         end
         ST_SQ_Y: begin
            mul_a = MA_W'(dy_ff);
            mul_b = MB_W'(dy_ff);
         end
         ST_RAD:    sqrt_start = 1'b1;
         ST_CP_MUL: begin
            mul_a = MA_W'(rd_ff);
            mul_b = MB_W'(rd_ff);
         end
         ST_M_NSQ: begin
            mul_a = MA_W'(sq_ff);
            mul_b = MB_W'(count_ff);
         end
         ST_M_SUM: begin
            mul_a = MA_W'(sum_ff);
            mul_b = MB_W'(sum_ff);
         end
         ST_M_NN: begin
            mul_a = MA_W'(count_ff);
            mul_b = MB_W'(count_ff);
         end
         ST_M_TN: begin
            mul_a = MA_W'(thr_ff);
            mul_b = MB_W'(count_ff);
         end
         ST_M_TT: begin
            mul_a = MA_W'(mul_p[MB_W-1:0]);
            mul_b = mul_p[MB_W-1:0];
         end
         ST_CMP:    div_start = 1'b1;
         ST_DIV_V: begin
            sqrt_start = div_done;
            sqrt_rad   = div_quo[RAD_W-1:0];
         end
         ST_SCORE: begin
            div_start = score_pos;
            div_num   = NUM_W'({good_ff, {SCORE_FRAC_W{1'b0}}});
            div_dvs   = DV_W'(image_total_ff - skip_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         image_total_ff <= IMAGE_TOTAL_RST;
         thr_ff         <= THRESHOLD_RST;
         count_ff       <= '0;
         sum_ff         <= '0;
         good_ff        <= '0;
         skip_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_IMAGE_TOTAL:     image_total_ff <= csr_wdata[IMG_W-1:0];
               CSR_MATCH_THRESHOLD: thr_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (state_ff == ST_OUT && out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_cmd == CMD_CLEAR) begin
                  good_ff <= '0;
                  skip_ff <= '0;
               end
            end
            ST_STORE: begin
               count_ff <= count_ff + 1'b1;
               sum_ff   <= sum_ff + SUM_W'(sqrt_root);
            end
            ST_DECIDE: begin
               if (!rf_ff) begin
                  if (skip_ff != COUNT_MAX) skip_ff <= skip_ff + 1'b1;
                  count_ff <= '0;
                  sum_ff   <= '0;
               end else if (!(tf_ff && count_ff != '0)) begin
                  count_ff <= '0;
                  sum_ff   <= '0;
               end
            end
            ST_ROOT_V: begin
               if (sqrt_done) begin
                  if (hit_ff && good_ff != COUNT_MAX) good_ff <= good_ff + 1'b1;
                  count_ff <= '0;
                  sum_ff   <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rf_ff   <= req_reference_found;
               tf_ff   <= req_test_found;
               last_ff <= req_last;
               dx_ff   <= (req_ref_x >= req_test_x) ? req_ref_x - req_test_x
                                                    : req_test_x - req_ref_x;
               dy_ff   <= (req_ref_y >= req_test_y) ? req_ref_y - req_test_y
                                                    : req_test_y - req_ref_y;
            end
         end
         ST_SQ_Y: acc_ff <= mul_p[NUM_W-1:0];
         ST_DECIDE: begin
            idx_ff  <= '0;
            sq_ff   <= '0;
            dev_ff  <= '0;
            devv_ff <= 1'b0;
            hit_ff  <= 1'b0;
         end
         ST_CP_ACC: begin
            sq_ff  <= sq_ff + mul_p[SQ_W-1:0];
            idx_ff <= idx_ff + 1'b1;
         end
         ST_M_SUM: acc_ff <= mul_p[NUM_W-1:0];
         ST_M_NN:  num_ff <= acc_ff - mul_p[NUM_W-1:0];
         ST_M_TN:  den_ff <= mul_p[DV_W-1:0];
         ST_CMP:   hit_ff <= num_ff <= mul_p[NUM_W-1:0];
         ST_ROOT_V: begin
            if (sqrt_done) begin
               dev_ff  <= sqrt_root;
               devv_ff <= 1'b1;
            end
         end
         ST_SCORE: begin
            if (!score_pos) begin
               score_ff <= '0;
               sv_ff    <= 1'b0;
            end
         end
         ST_DIV_S: begin
            if (div_done) begin
               score_ff <= score_sat;
               sv_ff    <= 1'b1;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_deviation_ff       <= dev_ff;
               rsp_deviation_valid_ff <= devv_ff;
               rsp_good_match_ff      <= hit_ff;
               rsp_good_count_ff      <= good_ff;
               rsp_skipped_count_ff   <= skip_ff;
               rsp_score_ff           <= score_ff;
               rsp_score_valid_ff     <= sv_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_STORE) mem[count_ff[AW-1:0]] <= sqrt_root;
      rd_ff <= mem[idx_ff[AW-1:0]];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_deviation       = rsp_deviation_ff;
   assign rsp_deviation_valid = rsp_deviation_valid_ff;
   assign rsp_good_match      = rsp_good_match_ff;
   assign rsp_good_count      = rsp_good_count_ff;
   assign rsp_skipped_count   = rsp_skipped_count_ff;
   assign rsp_score           = rsp_score_ff;
   assign rsp_score_valid     = rsp_score_valid_ff;

endmodule

@@ rtl/cdms_checker.sv @@
// ============================================================================
// Corner deviation match scorer checker
// Port-level checks on the request and result channels, bound to the top.
// ============================================================================
`include "corner_deviation_match_scorer_assert.svh"

module cdms_checker
   import cdms_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_cmd,
   input logic               req_last,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [D_W-1:0]     rsp_deviation,
   input logic               rsp_deviation_valid,
   input logic               rsp_good_match,
   input logic [SCORE_W-1:0] rsp_score,
   input logic               rsp_score_valid
);

   logic req_close;
   logic rsp_hold;

   assign req_close = req_valid && !req_stall && req_cmd == CMD_SAMPLE && req_last;
   assign rsp_hold  = rsp_valid && rsp_stall;

   `CDMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_hold, rsp_valid && $stable(rsp_score))
   `CDMS_ASSERT_NEXT(a_busy_after_last, clock, reset, req_close, req_stall)
   `CDMS_ASSERT_NOW(a_score_cap, clock, reset, rsp_valid, !rsp_score[16] || rsp_score[15:0] == '0)
   `CDMS_ASSERT_NOW(a_no_dev, clock, reset, rsp_valid && !rsp_deviation_valid, !rsp_good_match && rsp_deviation == '0)
   `CDMS_ASSERT_NOW(a_no_score, clock, reset, rsp_valid && !rsp_score_valid, rsp_score == '0)

endmodule

bind corner_deviation_match_scorer cdms_checker u_cdms_checker (.*);
